@@ sv/spoc_pkg.sv @@
// spoc_pkg: shared types and constants for the stack pop order checker.
// Used by every module of the block but spoc_ram; depends on nothing.
package spoc_pkg;

   localparam int unsigned MaxLenDefault = 1024;
   localparam int unsigned DataWidth     = 32;

   // One input word: next push value, next pop value, end-of-sequence mark.
   typedef struct packed {
      logic signed [DataWidth-1:0] push_value;
      logic signed [DataWidth-1:0] pop_value;
      logic                        last_pair;
   } req_word_type;

   // One result word.
   typedef struct packed {
      logic order_valid;
      logic too_long;
   } rsp_word_type;

   // Controller to datapath.
   typedef struct packed {
      logic take;    // latch input word, push, store pop value
      logic pop;     // drop stack top, advance pop index, issue RAM reads
      logic load;    // refill cached top and wanted value from RAM data
      logic close;   // emit result, clear sequence
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic pop_ok;    // stack top matches wanted pop value
      logic last;      // current sequence ends with the latched word
      logic out_free;  // result register can take a new word
   } status_type;

endpackage

@@ sv/spoc_ram.sv @@
// spoc_ram: generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module spoc_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic                                        rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/spoc_ctrl.sv @@
// spoc_ctrl: sequencing state machine for the stack pop order checker.
// Depends on spoc_pkg for the command and status structs.
module spoc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  spoc_pkg::status_type  status,
   output spoc_pkg::cmd_type     cmd
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_CHECK = 4'b0010,
      ST_LOAD  = 4'b0100,
      ST_CLOSE = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.pop_ok) begin
               cmd.pop  = 1'b1;
               state_in = ST_LOAD;
            end else if (status.last) begin
               state_in = ST_CLOSE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            state_in = ST_CHECK;
         end
         ST_CLOSE: begin
            if (status.out_free) begin
               cmd.close = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ sv/spoc_datapath.sv @@
// spoc_datapath: stack and pop order stores, counters, cached top/wanted
// values, compare and result register. Depends on spoc_pkg and spoc_ram.
module spoc_datapath #(
   parameter int unsigned MAX_LEN = spoc_pkg::MaxLenDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  spoc_pkg::req_word_type req_word,
   input  spoc_pkg::cmd_type     cmd,
   output spoc_pkg::status_type  status,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output spoc_pkg::rsp_word_type rsp_word
);

   localparam int unsigned CW = $clog2(MAX_LEN + 1);
   localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int unsigned DW = spoc_pkg::DataWidth;
   localparam logic [CW-1:0] LimitCount = CW'(MAX_LEN);
   localparam logic [CW-1:0] One        = CW'(1);
   localparam logic [CW-1:0] Two        = CW'(2);

   logic [CW-1:0] depth_ff, pop_idx_ff, pair_cnt_ff;
   logic          ovf_ff, last_ff;
   logic [DW-1:0] top_ff, want_ff;
   logic          rsp_valid_ff;
   spoc_pkg::rsp_word_type rsp_word_ff;

   logic          full;
   logic          write_en;
   logic [CW-1:0] stack_rd_cnt, pop_rd_cnt;
   logic [DW-1:0] stack_rd_data, pop_rd_data;

   assign full     = (pair_cnt_ff >= LimitCount);
   assign write_en = cmd.take && !full;

   // next top sits one below the current top; next wanted value one past
   assign stack_rd_cnt = depth_ff - Two;
   assign pop_rd_cnt   = pop_idx_ff + One;

   spoc_ram #(.WIDTH(DW), .DEPTH(MAX_LEN)) u_stack_ram (
      .clock   (clock),
      .wr_en   (write_en),
      .wr_addr (depth_ff[AW-1:0]),
      .wr_data (req_word.push_value),
      .rd_en   (cmd.pop),
      .rd_addr (stack_rd_cnt[AW-1:0]),
      .rd_data (stack_rd_data)
   );

   spoc_ram #(.WIDTH(DW), .DEPTH(MAX_LEN)) u_pop_ram (
      .clock   (clock),
      .wr_en   (write_en),
      .wr_addr (pair_cnt_ff[AW-1:0]),
      .wr_data (req_word.pop_value),
      .rd_en   (cmd.pop),
      .rd_addr (pop_rd_cnt[AW-1:0]),
      .rd_data (pop_rd_data)
   );

   assign status.pop_ok   = !ovf_ff && (depth_ff != '0) && (pop_idx_ff < pair_cnt_ff)
                            && (top_ff == want_ff);
   assign status.last     = last_ff;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   // sequence counters and flags
   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff    <= '0;
         pop_idx_ff  <= '0;
         pair_cnt_ff <= '0;
         ovf_ff      <= 1'b0;
         last_ff     <= 1'b0;
      end else if (cmd.close) begin
         depth_ff    <= '0;
         pop_idx_ff  <= '0;
         pair_cnt_ff <= '0;
         ovf_ff      <= 1'b0;
         last_ff     <= 1'b0;
      end else if (cmd.take) begin
         last_ff <= req_word.last_pair;
         if (full) begin
            ovf_ff <= 1'b1;
         end else begin
            depth_ff    <= depth_ff + One;
            pair_cnt_ff <= pair_cnt_ff + One;
         end
      end else if (cmd.pop) begin
         depth_ff   <= depth_ff - One;
         pop_idx_ff <= pop_idx_ff + One;
      end
   end

   // cached stack top and wanted pop value; payload only
   always_ff @(posedge clock) begin
      if (write_en) begin
         top_ff <= req_word.push_value;
         if (pop_idx_ff == pair_cnt_ff) begin
            want_ff <= req_word.pop_value;
         end
      end else if (cmd.load) begin
         top_ff  <= stack_rd_data;
         want_ff <= pop_rd_data;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.close) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.close) begin
         rsp_word_ff.order_valid <= !ovf_ff && (pop_idx_ff == pair_cnt_ff);
         rsp_word_ff.too_long    <= ovf_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

@@ sv/stack_pop_order_checker_unit.sv @@
// Stack pop order checker: each word is taken, then compared; each matched pop
// adds a read of the one-read-port stack and pop order RAMs, then a compare.
// A word with last_pair set then closes the sequence, delayed while an earlier
// result sits stalled in the output register; its result shows in the output
// register on the cycle after, and the next word may enter meanwhile.
// Reset (synchronous, active high) empties the stack and counters; RAM
// contents are not cleared and no clearing pass is run.
//
// Top level: joins the controller and the datapath. Depends on spoc_pkg,
// spoc_ctrl, spoc_datapath, spoc_ram.
module stack_pop_order_checker_unit #(
   parameter int unsigned MAX_LEN = spoc_pkg::MaxLenDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   // input words: one push value and one pop value each
   input  logic                   req_valid,
   output logic                   req_stall,
   input  spoc_pkg::req_word_type req_word,
   // result words: one per sequence, on the word marked last
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output spoc_pkg::rsp_word_type rsp_word
);

   // Flow per word:
   //   IDLE  take word: write push value at stack depth, pop value at pair
   //         count; the push value becomes the cached top.
   //   CHECK compare cached top against the cached wanted pop value; on a
   //         match the stack shrinks by one, the pop index moves, both RAMs are read.
   //   LOAD  the RAM reads issued in CHECK refill both caches here.
   //   CLOSE after the last word, wait for the result register, then
   //         report and clear the sequence.
   // A word that arrives with the store full is not stored; it only marks overflow and records its last_pair mark.
   spoc_pkg::cmd_type    cmd;
   spoc_pkg::status_type status;

   spoc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   spoc_datapath #(.MAX_LEN(MAX_LEN)) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule

@@ sv/spoc_checker.sv @@
// spoc_checker: port-level assertions for the stack pop order checker,
// bound to the top level. Depends on spoc_pkg.
module spoc_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input spoc_pkg::req_word_type req_word,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input spoc_pkg::rsp_word_type rsp_word
);

   // a taken word keeps the input stalled while it is worked on
   a_take_then_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input taken on two cycles in a row");

   // overflowed sequence never reports a valid order
   a_overflow_invalid: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.too_long) |-> !rsp_word.order_valid)
      else $error("too_long result reported as valid order");

   // no result leaves the cycle after reset
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_word)))
      else $error("stalled result dropped or changed");

   // stalled input word holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_stall) |=> (req_valid && $stable(req_word)))
      else $error("stalled input word dropped or changed");

endmodule

bind stack_pop_order_checker_unit spoc_checker u_spoc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_word  (req_word),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);
